// ----- src/sccbw_pkg.sv -----
// Shared types, constants and line-level function for the SCCB write master.
package sccbw_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int BITS_PER_BYTE   = 8;
	localparam int FRAME_BYTES     = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_ADDR_W      = 4;

	localparam logic [7:0]  DEV_ADDR_RST = 8'h42;
	localparam logic [15:0] TICKS_RST    = 16'd1;
	localparam logic [15:0] GAP_RST      = 16'd200;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_DATA  = 3'd2,
		PH_STOP  = 3'd3,
		PH_GAP   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REG_DEV_ADDR = 2'd0,
		REG_TICKS    = 2'd1,
		REG_GAP      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [15:0] ticks_per_segment;
		logic [15:0] gap_segments;
	} cfg_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic done;
		logic rejected;
	} result_t;

	// returns {scl, sda} for a given bus position
	function automatic logic [1:0] line_levels(
		input phase_t      ph,
		input logic [1:0]  seg,
		input logic [3:0]  bit_idx,
		input logic [1:0]  byte_idx,
		input logic [23:0] frame
	);
		logic [7:0] byte_sel;
		logic       b;
		logic [1:0] lv;
		case (byte_idx)
			2'd0:    byte_sel = frame[23:16];
			2'd1:    byte_sel = frame[15:8];
			2'd2:    byte_sel = frame[7:0];
			default: byte_sel = 8'd0;
		endcase
		b = (bit_idx < 4'(BITS_PER_BYTE)) ? byte_sel[3'(7 - bit_idx[2:0])] : 1'b0;
		case (ph)
			PH_START: lv = {seg < 2'd2, seg == 2'd0};
			PH_DATA:  lv = {seg == 2'd1, b};
			PH_STOP:  lv = {seg >= 2'd1, seg == 2'd2};
			default:  lv = 2'b11;
		endcase
		return lv;
	endfunction

endpackage

// ----- src/sccbw_cfg.sv -----
// APB configuration registers of the SCCB write master.
module sccbw_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sccbw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [sccbw_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [sccbw_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready,
	output sccbw_pkg::cfg_t                     cfg
);

	sccbw_pkg::cfg_t      cfg_q;
	sccbw_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx    = sccbw_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= sccbw_pkg::DEV_ADDR_RST;
			cfg_q.ticks_per_segment <= sccbw_pkg::TICKS_RST;
			cfg_q.gap_segments      <= sccbw_pkg::GAP_RST;
		end else if (wr_en) begin
			case (idx)
				sccbw_pkg::REG_DEV_ADDR: cfg_q.device_address    <= pwdata[7:0];
				sccbw_pkg::REG_TICKS:    cfg_q.ticks_per_segment <= pwdata[15:0];
				sccbw_pkg::REG_GAP:      cfg_q.gap_segments      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sccbw_pkg::REG_DEV_ADDR: prdata = {24'd0, cfg_q.device_address};
			sccbw_pkg::REG_TICKS:    prdata = {16'd0, cfg_q.ticks_per_segment};
			sccbw_pkg::REG_GAP:      prdata = {16'd0, cfg_q.gap_segments};
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- src/sccbw_engine.sv -----
// Bus sequencer: segment timer, bit/byte counters and line levels.
module sccbw_engine #(
	parameter int TIMER_WIDTH = sccbw_pkg::TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 mode,
	input  logic [7:0]           sub_address,
	input  logic [7:0]           write_value,
	input  sccbw_pkg::cfg_t      cfg,
	output sccbw_pkg::result_t   res
);

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	sccbw_pkg::phase_t       phase_q, phase_d;
	logic [1:0]              seg_q, seg_d;
	logic [3:0]              bit_q, bit_d;
	logic [1:0]              byte_q, byte_d;
	logic [23:0]             frame_q, frame_d;
	logic [TIMER_WIDTH-1:0]  tick_q, tick_d, tick_inc;
	logic [TIMER_WIDTH-1:0]  gap_q, gap_d, gap_inc;
	logic [15:0]             limit;
	logic                    seg_end;
	logic                    done;
	logic                    rejected;
	logic [1:0]              lv;

	assign tick_inc = tick_q + 1'b1;
	assign gap_inc  = gap_q + 1'b1;
	assign limit    = (cfg.ticks_per_segment == 16'd0) ? 16'd1 : cfg.ticks_per_segment;
	assign seg_end  = CMP_W'(tick_inc) >= CMP_W'(limit);

	always_comb begin
		phase_d  = phase_q;
		seg_d    = seg_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		frame_d  = frame_q;
		tick_d   = tick_q;
		gap_d    = gap_q;
		done     = 1'b0;
		rejected = 1'b0;
		if (!mode) begin
			if (phase_q != sccbw_pkg::PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				frame_d = {cfg.device_address, sub_address, write_value};
				phase_d = sccbw_pkg::PH_START;
				seg_d   = '0;
				bit_d   = '0;
				byte_d  = '0;
				tick_d  = '0;
				gap_d   = '0;
			end
		end else if (phase_q != sccbw_pkg::PH_IDLE) begin
			if (!seg_end) begin
				tick_d = tick_inc;
			end else begin
				tick_d = '0;
				case (phase_q)
					sccbw_pkg::PH_START: begin
						if (seg_q < 2'd2) begin
							seg_d = seg_q + 2'd1;
						end else begin
							phase_d = sccbw_pkg::PH_DATA;
							seg_d   = '0;
							bit_d   = '0;
							byte_d  = '0;
						end
					end
					sccbw_pkg::PH_DATA: begin
						if (seg_q < 2'd2) begin
							seg_d = seg_q + 2'd1;
						end else begin
							seg_d = '0;
							if (bit_q < 4'(sccbw_pkg::BITS_PER_BYTE)) begin
								bit_d = bit_q + 4'd1;
							end else begin
								bit_d = '0;
								if (byte_q < 2'(sccbw_pkg::FRAME_BYTES - 1)) begin
									byte_d = byte_q + 2'd1;
								end else begin
									byte_d  = '0;
									phase_d = sccbw_pkg::PH_STOP;
								end
							end
						end
					end
					sccbw_pkg::PH_STOP: begin
						if (seg_q < 2'd2) begin
							seg_d = seg_q + 2'd1;
						end else begin
							seg_d = '0;
							gap_d = '0;
							if (cfg.gap_segments == 16'd0) begin
								phase_d = sccbw_pkg::PH_IDLE;
								done    = 1'b1;
							end else begin
								phase_d = sccbw_pkg::PH_GAP;
							end
						end
					end
					sccbw_pkg::PH_GAP: begin
						if (CMP_W'(gap_inc) >= CMP_W'(cfg.gap_segments)) begin
							gap_d   = '0;
							phase_d = sccbw_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							gap_d = gap_inc;
						end
					end
					default: phase_d = sccbw_pkg::PH_IDLE;
				endcase
			end
		end
	end

	assign lv = sccbw_pkg::line_levels(phase_d, seg_d, bit_d, byte_d, frame_d);

	always_comb begin
		res.scl      = lv[1];
		res.sda      = lv[0];
		res.busy     = phase_d != sccbw_pkg::PH_IDLE;
		res.done     = done;
		res.rejected = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sccbw_pkg::PH_IDLE;
			seg_q   <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			frame_q <= '0;
			tick_q  <= '0;
			gap_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			seg_q   <= seg_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			frame_q <= frame_d;
			tick_q  <= tick_d;
			gap_q   <= gap_d;
		end
	end

endmodule

// ----- src/sccb_three_phase_write_master.sv -----
// Top level of the SCCB three-phase write master.
// A word is held in the input register, then its result in the output register.
// Throughput: one word per cycle unless out_ready stalls the output. The engine
// state and output register move together; an empty input register also loads.
// Reset (arst_n low, asynchronous): sequencer idle, config
// registers at their defaults, input and output registers empty.
module sccb_three_phase_write_master #(
	parameter int TIMER_WIDTH = sccbw_pkg::TIMER_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [7:0]                       sub_address,
	input  logic [7:0]                       write_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             scl,
	output logic                             sda,
	output logic                             busy_res,
	output logic                             write_done,
	output logic                             request_rejected,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sccbw_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [sccbw_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [sccbw_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);

	sccbw_pkg::cfg_t     cfg;
	sccbw_pkg::result_t  res, res_q;
	logic                valid_s1;
	logic                mode_s1;
	logic [7:0]          sub_s1;
	logic [7:0]          val_s1;
	logic                out_valid_q;
	logic                advance;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	sccbw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sccbw_engine #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.mode        (mode_s1),
		.sub_address (sub_s1),
		.write_value (val_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			sub_s1  <= sub_address;
			val_s1  <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign scl              = res_q.scl;
	assign sda              = res_q.sda;
	assign busy_res         = res_q.busy;
	assign write_done       = res_q.done;
	assign request_rejected = res_q.rejected;

endmodule
